// ----- hdl/window_sender_fast_retransmit_defines.svh -----
// Assertion macros for the window sender with fast retransmit.
`ifndef WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH
`define WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define WSFR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define WSFR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSFR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define WSFR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/wsfr_pkg.sv -----
// Shared types, constants and helpers for the window sender.
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

    localparam int WINDOW_SIZE  = 4;
    localparam int PAYLOAD_BITS = 64;
    localparam int SEQ_BITS     = 16;
    localparam int DUP_BITS     = 4;
    localparam int SLOT_BITS    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    localparam logic [DUP_BITS-1:0] DUP_THRESHOLD_RESET = DUP_BITS'(3);

    typedef logic [SEQ_BITS-1:0]     seq_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [SLOT_BITS-1:0]    slot_t;
    typedef logic [DUP_BITS-1:0]     dup_t;

    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_TIMEOUT = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t    mode;
        payload_t payload;
        seq_t     ack_number;
        logic     ack_checksum_ok;
        seq_t     timer_seq;
    } in_beat_t;

    typedef struct packed {
        logic     accepted;
        logic     window_full;
        logic     tx_valid;
        seq_t     tx_seq;
        payload_t tx_payload;
        logic     timer_stop;
        seq_t     stop_seq;
        logic     timer_start;
        seq_t     start_seq;
    } out_beat_t;

    // Result fields produced by the control logic (payload comes from the store)
    typedef struct packed {
        logic accepted;
        logic window_full;
        logic tx_valid;
        seq_t tx_seq;
        logic timer_stop;
        seq_t stop_seq;
        logic timer_start;
        seq_t start_seq;
    } status_t;

    // Store access for one accepted beat
    typedef struct packed {
        logic     load;
        logic     write;
        logic     read;
        slot_t    slot;
        payload_t wdata;
    } store_cmd_t;

    function automatic slot_t slot_of(input seq_t seq);
        return SLOT_BITS'(seq % WINDOW_SIZE);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/wsfr_store.sv -----
// Window payload store: one-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wsfr_store (
    input  wire logic                  clk,
    input  wire wsfr_pkg::store_cmd_t  cmd,
    output wsfr_pkg::payload_t         rdata
);

    wsfr_pkg::payload_t mem [wsfr_pkg::WINDOW_SIZE];
    wsfr_pkg::payload_t rdata_reg;

    // Write the sent payload into its slot
    always_ff @(posedge clk)
    begin
        if (cmd.load && cmd.write)
        begin
            mem[cmd.slot] <= cmd.wdata;
        end
    end

    // Register the transmitted payload: new data on a send, stored data on a resend, zero otherwise
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.write)
            begin
                rdata_reg <= cmd.wdata;
            end
            else if (cmd.read)
            begin
                rdata_reg <= mem[cmd.slot];
            end
            else
            begin
                rdata_reg <= '0;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/wsfr_ctrl.sv -----
// Window control: base, next sequence, duplicate count and per-beat decisions.
`timescale 1ns / 1ps
`default_nettype none

module wsfr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire wsfr_pkg::in_beat_t    in_data,
    input  wire logic                  cfg_we,
    input  wire wsfr_pkg::dup_t        cfg_data,
    output wsfr_pkg::status_t          status,
    output wsfr_pkg::store_cmd_t       cmd
);

    wsfr_pkg::seq_t    base_reg, base_next;
    wsfr_pkg::seq_t    next_seq_reg, next_seq_next;
    wsfr_pkg::dup_t    dup_reg, dup_next;
    wsfr_pkg::dup_t    thr_reg;
    wsfr_pkg::status_t status_reg, status_next;
    wsfr_pkg::dup_t    dup_inc;
    wsfr_pkg::seq_t    occ_now, occ_after;
    logic              full_now;

    assign occ_now  = next_seq_reg - base_reg;
    assign full_now = (occ_now >= wsfr_pkg::SEQ_BITS'(wsfr_pkg::WINDOW_SIZE));
    assign dup_inc  = dup_reg + wsfr_pkg::DUP_BITS'(1);
    assign occ_after = next_seq_next - base_next;

    // Decide the result and next state of the current beat
    always_comb
    begin
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        dup_next      = dup_reg;
        status_next   = '0;
        cmd.load      = load;
        cmd.write     = 1'b0;
        cmd.read      = 1'b0;
        cmd.slot      = wsfr_pkg::slot_of(base_reg);
        cmd.wdata     = in_data.payload;

        case (in_data.mode)
            wsfr_pkg::MODE_SEND:
            begin
                if (!full_now)
                begin
                    status_next.accepted = 1'b1;
                    if (base_reg == next_seq_reg)
                    begin
                        status_next.timer_start = 1'b1;
                        status_next.start_seq   = base_reg;
                    end
                    status_next.tx_valid = 1'b1;
                    status_next.tx_seq   = next_seq_reg;
                    cmd.write            = 1'b1;
                    cmd.slot             = wsfr_pkg::slot_of(next_seq_reg);
                    next_seq_next        = next_seq_reg + wsfr_pkg::SEQ_BITS'(1);
                end
            end
            wsfr_pkg::MODE_ACK:
            begin
                if (in_data.ack_checksum_ok)
                begin
                    if (in_data.ack_number == base_reg && dup_inc == thr_reg)
                    begin
                        // Fast retransmit of the base packet
                        dup_next                = '0;
                        cmd.read                = 1'b1;
                        status_next.tx_valid    = 1'b1;
                        status_next.tx_seq      = base_reg;
                        status_next.timer_stop  = 1'b1;
                        status_next.stop_seq    = base_reg;
                        status_next.timer_start = 1'b1;
                        status_next.start_seq   = base_reg + wsfr_pkg::SEQ_BITS'(1);
                    end
                    else
                    begin
                        dup_next = (in_data.ack_number == base_reg) ? dup_inc : '0;
                        status_next.timer_stop = 1'b1;
                        if (base_reg == next_seq_reg)
                        begin
                            status_next.stop_seq = base_reg;
                        end
                        else
                        begin
                            // Move the base to the ack number
                            base_next               = in_data.ack_number;
                            status_next.stop_seq    = in_data.ack_number;
                            status_next.timer_start = 1'b1;
                            status_next.start_seq   = in_data.ack_number
                                                      + wsfr_pkg::SEQ_BITS'(1);
                        end
                    end
                end
            end
            wsfr_pkg::MODE_TIMEOUT:
            begin
                status_next.timer_stop  = 1'b1;
                status_next.stop_seq    = in_data.timer_seq;
                status_next.timer_start = 1'b1;
                status_next.start_seq   = in_data.timer_seq;
                status_next.tx_valid    = 1'b1;
                status_next.tx_seq      = base_reg;
                cmd.read                = 1'b1;
            end
            default:
            begin
            end
        endcase

        status_next.window_full =
            (occ_after >= wsfr_pkg::SEQ_BITS'(wsfr_pkg::WINDOW_SIZE));
    end

    // Advance window state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            next_seq_reg <= '0;
            dup_reg      <= '0;
        end
        else if (load)
        begin
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            dup_reg      <= dup_next;
        end
    end

    // Hold the duplicate-ack threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= wsfr_pkg::DUP_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Register the result fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

`default_nettype wire

// ----- hdl/window_sender_fast_retransmit.sv -----
// Top level of the sliding-window sender with fast retransmit.
`timescale 1ns / 1ps
`default_nettype none
`include "window_sender_fast_retransmit_defines.svh"

// Sliding-window sender: takes one event beat (send, ack, timeout) per clock
// and returns exactly one registered result beat for each. Unless stalled, it
// sustains one beat per cycle: each beat does at most one access to the
// payload store (a write for a send, a registered read of the base slot for a
// resend) and the window counters update in the same cycle. The result sits
// in an output register; while it is stalled, in_stall follows out_stall so no
// beat is lost. The duplicate-ack threshold resets to 3 and may be written
// through the cfg channel whenever the block is idle; cfg_ready is always high.

module window_sender_fast_retransmit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire wsfr_pkg::in_beat_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output wsfr_pkg::out_beat_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire wsfr_pkg::dup_t       cfg_data
);

    logic                 out_valid_reg, out_valid_next;
    logic                 load;
    wsfr_pkg::status_t    status;
    wsfr_pkg::store_cmd_t cmd;
    wsfr_pkg::payload_t   tx_payload;

    // Take a new beat unless a result is held by the consumer
    assign in_stall  = out_valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    wsfr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .in_data (in_data),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_data(cfg_data),
        .status  (status),
        .cmd     (cmd)
    );

    wsfr_store u_store (
        .clk  (clk),
        .cmd  (cmd),
        .rdata(tx_payload)
    );

    // Track the output register occupancy
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Assemble the result beat
    always_comb
    begin
        out_data.accepted    = status.accepted;
        out_data.window_full = status.window_full;
        out_data.tx_valid    = status.tx_valid;
        out_data.tx_seq      = status.tx_seq;
        out_data.tx_payload  = tx_payload;
        out_data.timer_stop  = status.timer_stop;
        out_data.stop_seq    = status.stop_seq;
        out_data.timer_start = status.timer_start;
        out_data.start_seq   = status.start_seq;
    end

    assign out_valid = out_valid_reg;

    `WSFR_ASSERT_NXT(a_load_gives_result, clk, rst_n, load, out_valid, "accepted beat gave no result")
    `WSFR_ASSERT_NXT(a_send_payload_fwd, clk, rst_n, load && in_data.mode == wsfr_pkg::MODE_SEND, !out_data.accepted || out_data.tx_payload == $past(in_data.payload), "sent payload mismatch")
    `WSFR_ASSERT_IMP(a_accept_tx, clk, rst_n, out_valid && out_data.accepted, out_data.tx_valid && !out_data.timer_stop, "accepted send without transmit")

endmodule

`default_nettype wire

// ----- test/tb_window_sender_fast_retransmit.sv -----
// Self-checking testbench for the sliding-window sender with fast retransmit.
`timescale 1ns / 1ps

module tb_window_sender_fast_retransmit;
    import wsfr_pkg::*;

    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   PHASE_EVENTS  = 300;
    localparam int   DRAIN_CYCLES  = 6;
    localparam mode_t MODE_SPARE   = mode_t'(2'd3);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    dup_t      cfg_data;

    // Sender model state
    seq_t      win_base;
    seq_t      nxt_seq;
    dup_t      dup_cnt;
    dup_t      dup_limit;
    payload_t  slot_data [WINDOW_SIZE];

    // Expected result beats, oldest first
    out_beat_t pending_results [$];
    out_beat_t want_beat;

    // Directed plan
    in_beat_t  plan_event [$];
    bit        plan_typed [$];
    out_beat_t plan_want  [$];

    bit        calm;
    int        dup_burst;
    int        mismatches;
    int        cycles;
    int        n_events;
    int        n_checked;
    int        n_fast;
    int        n_timeouts;
    int        n_refused;

    window_sender_fast_retransmit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic seq_t in_flight();
        return seq_t'(nxt_seq - win_base);
    endfunction

    function automatic bit window_is_full();
        return in_flight() >= WINDOW_SIZE;
    endfunction

    function automatic int slot_index(input seq_t seq);
        return int'(seq % WINDOW_SIZE);
    endfunction

    // Advance the sender model by one event and return the result beat it gives
    function automatic out_beat_t apply_event(input in_beat_t ev);
        out_beat_t r;
        bit        fired;
        r = '0;
        fired = 1'b0;
        case (ev.mode)
            MODE_SEND:
            begin
                if (!window_is_full())
                begin
                    r.accepted = 1'b1;
                    if (win_base == nxt_seq)
                    begin
                        r.timer_start = 1'b1;
                        r.start_seq   = win_base;
                    end
                    r.tx_valid   = 1'b1;
                    r.tx_seq     = nxt_seq;
                    r.tx_payload = ev.payload;
                    slot_data[slot_index(nxt_seq)] = ev.payload;
                    nxt_seq = nxt_seq + 1'b1;
                end
                else
                begin
                    n_refused++;
                end
            end
            MODE_ACK:
            begin
                if (ev.ack_checksum_ok)
                begin
                    // Count duplicates of the base; fire at the threshold
                    if (ev.ack_number == win_base)
                    begin
                        dup_cnt = dup_cnt + 1'b1;
                        if (dup_cnt == dup_limit)
                        begin
                            r.tx_valid    = 1'b1;
                            r.tx_seq      = win_base;
                            r.tx_payload  = slot_data[slot_index(win_base)];
                            r.timer_stop  = 1'b1;
                            r.stop_seq    = win_base;
                            r.timer_start = 1'b1;
                            r.start_seq   = win_base + 1'b1;
                            dup_cnt = '0;
                            fired = 1'b1;
                            n_fast++;
                        end
                    end
                    else
                    begin
                        dup_cnt = '0;
                    end
                    if (!fired)
                    begin
                        if (win_base == nxt_seq)
                        begin
                            r.timer_stop = 1'b1;
                            r.stop_seq   = win_base;
                        end
                        else
                        begin
                            win_base = ev.ack_number;
                            r.timer_stop  = 1'b1;
                            r.stop_seq    = win_base;
                            r.timer_start = 1'b1;
                            r.start_seq   = win_base + 1'b1;
                        end
                    end
                end
            end
            MODE_TIMEOUT:
            begin
                r.timer_stop  = 1'b1;
                r.stop_seq    = ev.timer_seq;
                r.timer_start = 1'b1;
                r.start_seq   = ev.timer_seq;
                r.tx_valid    = 1'b1;
                r.tx_seq      = win_base;
                r.tx_payload  = slot_data[slot_index(win_base)];
                n_timeouts++;
            end
            default:
            begin
            end
        endcase
        r.window_full = window_is_full();
        return r;
    endfunction

    function automatic in_beat_t ev_send(input payload_t p);
        in_beat_t ev;
        ev = '0;
        ev.mode = MODE_SEND;
        ev.payload = p;
        return ev;
    endfunction

    function automatic in_beat_t ev_ack(input seq_t num, input logic ok);
        in_beat_t ev;
        ev = '0;
        ev.mode = MODE_ACK;
        ev.ack_number = num;
        ev.ack_checksum_ok = ok;
        return ev;
    endfunction

    function automatic in_beat_t ev_timeout(input seq_t tag);
        in_beat_t ev;
        ev = '0;
        ev.mode = MODE_TIMEOUT;
        ev.timer_seq = tag;
        return ev;
    endfunction

    function automatic in_beat_t ev_spare();
        in_beat_t ev;
        ev = '1;
        ev.mode = MODE_SPARE;
        return ev;
    endfunction

    task automatic add_row(input in_beat_t ev, input bit typed, input out_beat_t want);
        plan_event.push_back(ev);
        plan_typed.push_back(typed);
        plan_want.push_back(want);
    endtask

    // Pick a random event; mostly well-formed traffic around the current window
    function automatic in_beat_t pick_event();
        in_beat_t ev;
        int       r;
        int       sel;
        seq_t     occ;
        ev.mode            = MODE_SEND;
        ev.payload         = {$urandom, $urandom};
        ev.ack_number      = seq_t'($urandom);
        ev.ack_checksum_ok = 1'b1;
        ev.timer_seq       = seq_t'($urandom);
        occ = in_flight();
        if (dup_burst > 0)
        begin
            dup_burst--;
            ev.mode = MODE_ACK;
            ev.ack_number = win_base;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                ev.mode = MODE_SEND;
            end
            else if (r < 75)
            begin
                ev.mode = MODE_ACK;
                sel = $urandom_range(9);
                if (sel < 3)
                    ev.ack_number = win_base;
                else if (sel < 7 && occ >= 1 && occ <= WINDOW_SIZE)
                    ev.ack_number = win_base + seq_t'($urandom_range(int'(occ), 1));
                else if (sel < 8)
                    ev.ack_number = nxt_seq;
            end
            else if (r < 80)
            begin
                ev.mode = MODE_ACK;
                ev.ack_checksum_ok = 1'b0;
                if ($urandom_range(1) == 0)
                    ev.ack_number = win_base;
            end
            else if (r < 92)
            begin
                ev.mode = MODE_TIMEOUT;
            end
            else if (r < 96)
            begin
                // Start a run of 2 to 18 duplicate acks; the longest run reaches any threshold
                ev.mode = MODE_ACK;
                ev.ack_number = win_base;
                dup_burst = $urandom_range(17, 1);
            end
            else
            begin
                ev.mode = MODE_SPARE;
            end
        end
        return ev;
    endfunction

    // Offer one beat, hold it until taken, then record the expected result
    task automatic push_event(input in_beat_t ev, input bit typed, input out_beat_t want);
        out_beat_t predicted;
        int        gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 24)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predicted = apply_event(ev);
        pending_results.push_back(typed ? want : predicted);
        n_events++;
    endtask

    // Wait for the block to drain, then write the duplicate-ack threshold
    task automatic write_threshold(input dup_t value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dup_limit = value;
    endtask

    // Receiver side: random stall, compare each taken beat with the oldest expectation
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 24);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("result beat with nothing expected: %h", out_data));
            end
            else
            begin
                want_beat = pending_results.pop_front();
                n_checked++;
                if (out_data.accepted !== want_beat.accepted)
                    flag_mismatch($sformatf("beat %0d accepted got %b want %b",
                        n_checked, out_data.accepted, want_beat.accepted));
                if (out_data.window_full !== want_beat.window_full)
                    flag_mismatch($sformatf("beat %0d window_full got %b want %b",
                        n_checked, out_data.window_full, want_beat.window_full));
                if (out_data.tx_valid !== want_beat.tx_valid)
                    flag_mismatch($sformatf("beat %0d tx_valid got %b want %b",
                        n_checked, out_data.tx_valid, want_beat.tx_valid));
                if (out_data.tx_seq !== want_beat.tx_seq)
                    flag_mismatch($sformatf("beat %0d tx_seq got %h want %h",
                        n_checked, out_data.tx_seq, want_beat.tx_seq));
                if (out_data.tx_payload !== want_beat.tx_payload)
                    flag_mismatch($sformatf("beat %0d tx_payload got %h want %h",
                        n_checked, out_data.tx_payload, want_beat.tx_payload));
                if (out_data.timer_stop !== want_beat.timer_stop)
                    flag_mismatch($sformatf("beat %0d timer_stop got %b want %b",
                        n_checked, out_data.timer_stop, want_beat.timer_stop));
                if (out_data.stop_seq !== want_beat.stop_seq)
                    flag_mismatch($sformatf("beat %0d stop_seq got %h want %h",
                        n_checked, out_data.stop_seq, want_beat.stop_seq));
                if (out_data.timer_start !== want_beat.timer_start)
                    flag_mismatch($sformatf("beat %0d timer_start got %b want %b",
                        n_checked, out_data.timer_start, want_beat.timer_start));
                if (out_data.start_seq !== want_beat.start_seq)
                    flag_mismatch($sformatf("beat %0d start_seq got %h want %h",
                        n_checked, out_data.start_seq, want_beat.start_seq));
            end
        end
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycles, pending_results.size());
            $display("window_sender_fast_retransmit: mismatch");
            $finish;
        end
    end

    initial
    begin
        dup_t thresholds [6];
        int   ph;
        int   i;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        calm       = 1'b0;
        dup_burst  = 0;
        mismatches = 0;
        cycles     = 0;
        n_events   = 0;
        n_checked  = 0;
        n_fast     = 0;
        n_timeouts = 0;
        n_refused  = 0;
        win_base   = '0;
        nxt_seq    = '0;
        dup_cnt    = '0;
        dup_limit  = DUP_THRESHOLD_RESET;
        for (i = 0; i < WINDOW_SIZE; i++)
            slot_data[i] = '0;

        // Directed opening: the first four sends fill every slot before any resend
        add_row(ev_send('1), 1'b1,
            '{accepted: 1'b1, window_full: 1'b0, tx_valid: 1'b1, tx_seq: 16'h0000,
              tx_payload: '1, timer_stop: 1'b0, stop_seq: 16'h0000,
              timer_start: 1'b1, start_seq: 16'h0000});
        add_row(ev_send('0), 1'b0, '0);
        add_row(ev_send(64'hA5A5_A5A5_A5A5_A5A5), 1'b0, '0);
        add_row(ev_send(64'h8000_0000_0000_0001), 1'b1,
            '{accepted: 1'b1, window_full: 1'b1, tx_valid: 1'b1, tx_seq: 16'h0003,
              tx_payload: 64'h8000_0000_0000_0001, timer_stop: 1'b0, stop_seq: 16'h0000,
              timer_start: 1'b0, start_seq: 16'h0000});
        // Full window refuses the send
        add_row(ev_send(64'h5A5A_5A5A_5A5A_5A5A), 1'b1,
            '{accepted: 1'b0, window_full: 1'b1, tx_valid: 1'b0, tx_seq: 16'h0000,
              tx_payload: '0, timer_stop: 1'b0, stop_seq: 16'h0000,
              timer_start: 1'b0, start_seq: 16'h0000});
        // Bad checksum is ignored
        add_row(ev_ack(16'h0000, 1'b0), 1'b1,
            '{accepted: 1'b0, window_full: 1'b1, tx_valid: 1'b0, tx_seq: 16'h0000,
              tx_payload: '0, timer_stop: 1'b0, stop_seq: 16'h0000,
              timer_start: 1'b0, start_seq: 16'h0000});
        // Unused mode only reports the window state
        add_row(ev_spare(), 1'b1,
            '{accepted: 1'b0, window_full: 1'b1, tx_valid: 1'b0, tx_seq: 16'h0000,
              tx_payload: '0, timer_stop: 1'b0, stop_seq: 16'h0000,
              timer_start: 1'b0, start_seq: 16'h0000});
        // Timeout restarts the timer on its own tag and resends the base
        add_row(ev_timeout(16'hFFFF), 1'b1,
            '{accepted: 1'b0, window_full: 1'b1, tx_valid: 1'b1, tx_seq: 16'h0000,
              tx_payload: '1, timer_stop: 1'b1, stop_seq: 16'hFFFF,
              timer_start: 1'b1, start_seq: 16'hFFFF});
        // Three duplicates of the base reach the reset threshold
        add_row(ev_ack(16'h0000, 1'b1), 1'b0, '0);
        add_row(ev_ack(16'h0000, 1'b1), 1'b0, '0);
        add_row(ev_ack(16'h0000, 1'b1), 1'b0, '0);
        // Advance the base, then jump it out of range, then back
        add_row(ev_ack(16'h0002, 1'b1), 1'b0, '0);
        add_row(ev_ack(16'hFFFF, 1'b1), 1'b0, '0);
        add_row(ev_ack(16'h0004, 1'b1), 1'b0, '0);
        // Duplicate on an empty window only stops the timer
        add_row(ev_ack(16'h0004, 1'b1), 1'b0, '0);
        add_row(ev_send(64'h0123_4567_89AB_CDEF), 1'b0, '0);
        add_row(ev_timeout(16'h0000), 1'b0, '0);
        add_row(ev_spare(), 1'b0, '0);
        add_row(ev_ack(16'h0005, 1'b0), 1'b0, '0);
        add_row(ev_ack(16'h0005, 1'b1), 1'b0, '0);

        // Hold reset, then release on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan_event.size(); i++)
            push_event(plan_event[i], plan_typed[i], plan_want[i]);

        // Random phases, each under its own threshold; phase one runs without idling
        thresholds[0] = DUP_THRESHOLD_RESET;
        thresholds[1] = dup_t'(1);
        thresholds[2] = dup_t'(15);
        thresholds[3] = dup_t'(0);
        thresholds[4] = dup_t'(8);
        thresholds[5] = dup_t'($urandom_range(15, 1));
        for (ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_threshold(thresholds[ph]);
            calm = (ph == 1);
            dup_burst = 0;
            for (i = 0; i < PHASE_EVENTS; i++)
                push_event(pick_event(), 1'b0, '0);
        end
        calm = 1'b0;

        // Drain and let the pipeline settle
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d events over 6 threshold settings: %0d results checked",
            n_events, n_checked);
        $display("  %0d fast retransmits, %0d timeouts, %0d refused sends, %0d mismatches",
            n_fast, n_timeouts, n_refused, mismatches);
        if (mismatches == 0)
        begin
            $display("window_sender_fast_retransmit: match");
        end
        else
        begin
            $display("window_sender_fast_retransmit: mismatch");
        end
        $finish;
    end

endmodule
